// ===== hdl/dvrt_pkg.sv =====
// Package: command and status codes, register map and configuration type.
`timescale 1ns / 1ps
package dvrt_pkg;

	localparam logic [2:0] CMD_INSTALL = 3'd0;
	localparam logic [2:0] CMD_REFRESH = 3'd1;
	localparam logic [2:0] CMD_ADVERT  = 3'd2;
	localparam logic [2:0] CMD_TICK    = 3'd3;
	localparam logic [2:0] CMD_IFDOWN  = 3'd4;
	localparam logic [2:0] CMD_LOOKUP  = 3'd5;
	localparam logic [2:0] CMD_DUMP    = 3'd6;
	localparam logic [2:0] CMD_UNUSED  = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_LOCAL    = 3'd1;
	localparam logic [2:0] ST_UNREACH  = 3'd2;
	localparam logic [2:0] ST_UNKNOWN  = 3'd3;
	localparam logic [2:0] ST_REJECT   = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;

	localparam logic [2:0] REG_INFINITY = 3'd0;
	localparam logic [2:0] REG_UPDATE   = 3'd1;
	localparam logic [2:0] REG_CHECK    = 3'd2;
	localparam logic [2:0] REG_TIMEOUT  = 3'd3;
	localparam logic [2:0] REG_IFMASK   = 3'd4;

	typedef struct packed {
		logic [4:0]  infinity_cost;
		logic [7:0]  update_period;
		logic [7:0]  check_period;
		logic [15:0] route_timeout;
		logic [15:0] interface_enable_mask;
	} cfg_t;

endpackage

// ===== hdl/dvrt_if.sv =====
// Interfaces: command channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface dvrt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] route_address;
	logic [31:0] neighbor_address;
	logic [7:0]  advertised_cost;
	logic [3:0]  interface_id;
	logic        install_local;
	logic        end_of_packet;

	modport source (output valid, cmd, route_address, neighbor_address, advertised_cost,
		interface_id, install_local, end_of_packet, input ready);
	modport sink (input valid, cmd, route_address, neighbor_address, advertised_cost,
		interface_id, install_local, end_of_packet, output ready);
endinterface

interface dvrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_address;
	logic [4:0]  out_cost;
	logic [3:0]  out_interface;
	logic        broadcast_due;
	logic        last_result;

	modport source (output valid, status, out_address, out_cost, out_interface,
		broadcast_due, last_result, input ready);
	modport sink (input valid, status, out_address, out_cost, out_interface,
		broadcast_due, last_result, output ready);
endinterface

// ===== hdl/dvrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/dvrt_cfg.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module dvrt_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output dvrt_pkg::cfg_t    cfg
);
	dvrt_pkg::cfg_t cfg_q;
	logic [2:0]     idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.infinity_cost         <= 5'd16;
			cfg_q.update_period         <= 8'd5;
			cfg_q.check_period          <= 8'd12;
			cfg_q.route_timeout         <= 16'd12;
			cfg_q.interface_enable_mask <= 16'hFFFF;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				dvrt_pkg::REG_INFINITY: cfg_q.infinity_cost         <= pwdata[4:0];
				dvrt_pkg::REG_UPDATE:   cfg_q.update_period         <= pwdata[7:0];
				dvrt_pkg::REG_CHECK:    cfg_q.check_period          <= pwdata[7:0];
				dvrt_pkg::REG_TIMEOUT:  cfg_q.route_timeout         <= pwdata[15:0];
				dvrt_pkg::REG_IFMASK:   cfg_q.interface_enable_mask <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			dvrt_pkg::REG_INFINITY: prdata = {27'd0, cfg_q.infinity_cost};
			dvrt_pkg::REG_UPDATE:   prdata = {24'd0, cfg_q.update_period};
			dvrt_pkg::REG_CHECK:    prdata = {24'd0, cfg_q.check_period};
			dvrt_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_q.route_timeout};
			dvrt_pkg::REG_IFMASK:   prdata = {16'd0, cfg_q.interface_enable_mask};
			default:                prdata = 32'd0;
		endcase
	end
endmodule

// ===== hdl/distance_vector_route_table_top.sv =====
// Top level: distance-vector route table, one RAM of routes and a command sequencer.
// Flow: every command scans the stored routes once, one entry a cycle, then decides and
// writes back (S_DEC, plus S_ADV2 for an accepted advertisement) and loads the result (S_FIN).
// One command at a time; the result waits in S_FIN while the output is stalled; a dump
// sends each route through S_DRD and S_DWT (one read port).
// Reset: asynchronous, clears count, timers and flags; the route RAM is not cleared.
`timescale 1ns / 1ps
module distance_vector_route_table_top #(
	parameter int TABLE_DEPTH     = 64,
	parameter int INTERFACE_COUNT = 16,
	parameter int STAMP_BITS      = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	dvrt_req_if.sink     req,
	dvrt_rsp_if.source   rsp
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = STAMP_BITS + 42;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_ADV2 = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DRD  = 3'd5;
	localparam logic [2:0] S_DWT  = 3'd6;

	dvrt_pkg::cfg_t cfg;

	dvrt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	function automatic logic [EW-1:0] pack(input logic [31:0] a, input logic [4:0] c,
		input logic [3:0] f, input logic l, input logic [STAMP_BITS-1:0] s);
		pack = {a, c, f, l, s};
	endfunction

	// route RAM
	logic          ram_we;
	logic [IW-1:0] ram_wa, ram_ra;
	logic [EW-1:0] ram_wd, ram_rd;

	dvrt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	logic [31:0]           rd_addr;
	logic [4:0]            rd_cost;
	logic [3:0]            rd_ifc;
	logic                  rd_loc;
	logic [STAMP_BITS-1:0] rd_stamp;
	assign {rd_addr, rd_cost, rd_ifc, rd_loc, rd_stamp} = ram_rd;

	// control and state registers
	logic [2:0]            state_q;
	logic [CW-1:0]         count_q, rd_ptr_q, dptr_q;
	logic [STAMP_BITS-1:0] now_q;
	logic [7:0]            upd_q, chk_q;
	logic                  pend_q, sweep_q, ufire_q, exp_q;
	logic                  v_s1;
	logic [IW-1:0]         idx_s1;
	logic                  fa_q, fb_q;
	logic [IW-1:0]         ia_q, ib_q;
	logic [EW-1:0]         enta_q, entb_q;

	// latched command
	logic [2:0]  cmd_q;
	logic [31:0] ra_q, nb_q;
	logic [7:0]  ac_q;
	logic [3:0]  if_q;
	logic        loc_q, eop_q;

	// pending result and output register
	logic [2:0]  rst_q;
	logic [31:0] raddr_q;
	logic [4:0]  rcost_q;
	logic [3:0]  rifc_q;
	logic        rbc_q;
	logic        ovalid_q;

	logic [31:0]           a_addr, b_addr;
	logic [4:0]            a_cost, b_cost;
	logic [3:0]            a_ifc, b_ifc;
	logic                  a_loc, b_loc;
	logic [STAMP_BITS-1:0] a_stamp, b_stamp;
	assign {a_addr, a_cost, a_ifc, a_loc, a_stamp} = enta_q;
	assign {b_addr, b_cost, b_ifc, b_loc, b_stamp} = entb_q;

	logic [4:0] inf;
	assign inf = cfg.infinity_cost;

	logic if_en, nb_ok, full, out_free;
	assign if_en    = (32'(if_q) < 32'(INTERFACE_COUNT)) && cfg.interface_enable_mask[if_q];
	assign nb_ok    = fb_q && !b_loc && if_en;
	assign full     = count_q >= CW'(TABLE_DEPTH);
	assign out_free = !ovalid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);

	// costs derived from the command
	logic [4:0] ins_cost, adv_c;
	logic [8:0] adv_c9;
	always_comb begin
		ins_cost = loc_q ? 5'd0 : ((ac_q < {3'd0, inf}) ? ac_q[4:0] : inf);
		adv_c9   = {1'b0, ac_q} + 9'd1;
		adv_c    = (adv_c9 > {4'd0, inf}) ? inf : adv_c9[4:0];
	end

	// advertised route against the stored one
	logic [4:0] new_cost;
	logic [3:0] new_ifc;
	logic       chg, trig;
	always_comb begin
		new_cost = a_cost;
		new_ifc  = a_ifc;
		chg      = 1'b0;
		trig     = 1'b0;
		if (a_cost < inf) begin
			if (adv_c < a_cost) begin
				new_cost = adv_c;
				new_ifc  = if_q;
				chg      = 1'b1;
			end else if (adv_c >= inf && a_ifc == if_q) begin
				new_cost = inf;
				chg      = 1'b1;
				trig     = 1'b1;
			end
		end else if (adv_c < inf) begin
			new_cost = adv_c;
			new_ifc  = if_q;
			chg      = 1'b1;
		end
	end

	// expiry and interface-down tests on the entry coming out of the scan
	logic [STAMP_BITS-1:0] age;
	logic                  expire, kill;
	always_comb begin
		age    = now_q - rd_stamp;
		expire = (cmd_q == dvrt_pkg::CMD_TICK) && sweep_q && !rd_loc && rd_cost < inf &&
			(32'(age) >= 32'(cfg.route_timeout));
		kill   = (cmd_q == dvrt_pkg::CMD_IFDOWN) && !rd_loc && rd_ifc == if_q;
	end

	// RAM port selection
	always_comb begin
		ram_we = 1'b0;
		ram_wa = '0;
		ram_wd = '0;
		ram_ra = '0;
		unique case (state_q)
			S_SCAN: begin
				ram_ra = rd_ptr_q[IW-1:0];
				if (v_s1 && (expire || kill)) begin
					ram_we = 1'b1;
					ram_wa = idx_s1;
					ram_wd = pack(rd_addr, inf, rd_ifc, rd_loc, rd_stamp);
				end
			end
			S_DEC: begin
				if (cmd_q == dvrt_pkg::CMD_INSTALL && (fa_q || !full)) begin
					ram_we = 1'b1;
					ram_wa = fa_q ? ia_q : count_q[IW-1:0];
					ram_wd = pack(ra_q, ins_cost, if_q, loc_q, now_q);
				end else if ((cmd_q == dvrt_pkg::CMD_REFRESH ||
					cmd_q == dvrt_pkg::CMD_ADVERT) && nb_ok) begin
					ram_we = 1'b1;
					ram_wa = ib_q;
					ram_wd = pack(nb_q, 5'd1, if_q, 1'b0, now_q);
				end
			end
			S_ADV2: begin
				if (!fa_q) begin
					if (!full) begin
						ram_we = 1'b1;
						ram_wa = count_q[IW-1:0];
						ram_wd = pack(ra_q, adv_c, if_q, 1'b0, now_q);
					end
				end else if (!a_loc && ra_q != nb_q) begin
					ram_we = 1'b1;
					ram_wa = ia_q;
					ram_wd = pack(ra_q, new_cost, new_ifc, 1'b0,
						(chg || new_ifc == if_q) ? now_q : a_stamp);
				end
			end
			S_DRD:   ram_ra = dptr_q[IW-1:0];
			default: ;
		endcase
	end

	// dumped entry as it leaves the RAM
	logic [4:0] d_cost;
	logic [3:0] d_ifc;
	always_comb begin
		d_cost = (!rd_loc && rd_addr != nb_q && rd_ifc == if_q) ? inf : rd_cost;
		d_ifc  = rd_loc ? 4'd0 : rd_ifc;
	end

	// tick counters on acceptance
	logic [7:0] upd_inc, chk_inc;
	assign upd_inc = (upd_q == 8'hFF) ? upd_q : upd_q + 8'd1;
	assign chk_inc = (chk_q == 8'hFF) ? chk_q : chk_q + 8'd1;

	logic pend_nx;
	assign pend_nx = pend_q | (state_q == S_ADV2 && fa_q && !a_loc && ra_q != nb_q && trig);

	// result fields and next state of the decision steps
	logic [2:0]  res_st;
	logic [31:0] res_addr;
	logic [4:0]  res_cost;
	logic [3:0]  res_ifc;
	logic        res_bc;
	logic [2:0]  dec_next;
	always_comb begin
		res_st   = dvrt_pkg::ST_OK;
		res_addr = ra_q;
		res_cost = 5'd0;
		res_ifc  = 4'd0;
		res_bc   = 1'b0;
		dec_next = S_FIN;
		if (state_q == S_ADV2) begin
			res_cost = adv_c;
			res_ifc  = if_q;
			if (!fa_q) begin
				if (full) begin
					res_st = dvrt_pkg::ST_FULL;
				end
			end else if (a_loc) begin
				res_st   = dvrt_pkg::ST_LOCAL;
				res_cost = a_cost;
				res_ifc  = 4'd0;
			end else if (ra_q == nb_q) begin
				res_cost = 5'd1;
			end else begin
				res_cost = new_cost;
				res_ifc  = new_ifc;
			end
			// report the trigger at the end of a packet
			res_bc = eop_q && pend_nx;
		end else begin
			unique case (cmd_q)
				dvrt_pkg::CMD_INSTALL: begin
					res_cost = ins_cost;
					res_ifc  = if_q;
					if (!fa_q && full) begin
						res_st = dvrt_pkg::ST_FULL;
					end
				end
				dvrt_pkg::CMD_REFRESH: begin
					res_addr = nb_q;
					res_ifc  = if_q;
					if (nb_ok) begin
						res_cost = 5'd1;
					end else begin
						res_st = dvrt_pkg::ST_REJECT;
					end
				end
				dvrt_pkg::CMD_ADVERT: begin
					if (nb_ok) begin
						dec_next = S_ADV2;
					end else begin
						res_st  = dvrt_pkg::ST_REJECT;
						res_ifc = if_q;
						res_bc  = eop_q && pend_q;
					end
				end
				dvrt_pkg::CMD_TICK: begin
					res_addr = 32'd0;
					res_bc   = ufire_q | exp_q;
				end
				dvrt_pkg::CMD_IFDOWN: begin
					res_ifc = if_q;
				end
				dvrt_pkg::CMD_LOOKUP: begin
					if (!fa_q) begin
						res_st = dvrt_pkg::ST_UNKNOWN;
					end else if (a_loc) begin
						res_st   = dvrt_pkg::ST_LOCAL;
						res_cost = a_cost;
					end else begin
						res_st   = (a_cost >= inf) ? dvrt_pkg::ST_UNREACH : dvrt_pkg::ST_OK;
						res_cost = a_cost;
						res_ifc  = a_ifc;
					end
				end
				dvrt_pkg::CMD_DUMP: begin
					if (count_q == '0) begin
						res_st = dvrt_pkg::ST_EMPTY;
					end else if (!(nb_ok && b_cost < inf)) begin
						res_st   = dvrt_pkg::ST_REJECT;
						res_addr = nb_q;
						res_ifc  = if_q;
					end else begin
						dec_next = S_DRD;
					end
				end
				default: begin
					res_st = dvrt_pkg::ST_UNKNOWN;
				end
			endcase
		end
	end

	// load the output register when a result is ready and the slot is free
	logic load_out;
	assign load_out = (state_q == S_FIN && out_free) || state_q == S_DWT;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			now_q    <= '0;
			upd_q    <= 8'd1;
			chk_q    <= 8'd1;
			pend_q   <= 1'b0;
			v_s1     <= 1'b0;
			ovalid_q <= 1'b0;
			rd_ptr_q <= '0;
			dptr_q   <= '0;
			fa_q     <= 1'b0;
			fb_q     <= 1'b0;
			exp_q    <= 1'b0;
			sweep_q  <= 1'b0;
			ufire_q  <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.cmd;
						ra_q     <= req.route_address;
						nb_q     <= req.neighbor_address;
						ac_q     <= req.advertised_cost;
						if_q     <= req.interface_id;
						loc_q    <= req.install_local;
						eop_q    <= req.end_of_packet;
						rd_ptr_q <= '0;
						v_s1     <= 1'b0;
						fa_q     <= 1'b0;
						fb_q     <= 1'b0;
						exp_q    <= 1'b0;
						ufire_q  <= (req.cmd == dvrt_pkg::CMD_TICK) &&
							(upd_inc >= cfg.update_period);
						sweep_q  <= (req.cmd == dvrt_pkg::CMD_TICK) &&
							(chk_inc >= cfg.check_period);
						if (req.cmd == dvrt_pkg::CMD_TICK) begin
							now_q <= now_q + 1'b1;
							upd_q <= (upd_inc >= cfg.update_period) ? 8'd1 : upd_inc;
							chk_q <= (chk_inc >= cfg.check_period) ? 8'd1 : chk_inc;
						end
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read a cycle, examine the previous one
					if (rd_ptr_q < count_q) begin
						v_s1     <= 1'b1;
						idx_s1   <= rd_ptr_q[IW-1:0];
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							state_q <= S_DEC;
						end
					end
					if (v_s1) begin
						if (!fa_q && rd_addr == ra_q) begin
							fa_q   <= 1'b1;
							ia_q   <= idx_s1;
							enta_q <= ram_rd;
						end
						if (!fb_q && rd_addr == nb_q) begin
							fb_q   <= 1'b1;
							ib_q   <= idx_s1;
							entb_q <= ram_rd;
						end
						if (expire) begin
							exp_q <= 1'b1;
						end
					end
				end
				S_DEC: begin
					rst_q   <= res_st;
					raddr_q <= res_addr;
					rcost_q <= res_cost;
					rifc_q  <= res_ifc;
					rbc_q   <= res_bc;
					state_q <= dec_next;
					unique case (cmd_q)
						dvrt_pkg::CMD_INSTALL: begin
							if (!fa_q && !full) begin
								count_q <= count_q + 1'b1;
							end
						end
						dvrt_pkg::CMD_ADVERT: begin
							// a rejected packet end still reports and clears the trigger
							if (!nb_ok && eop_q) begin
								pend_q <= 1'b0;
								if (pend_q) begin
									upd_q <= 8'd1;
								end
							end
						end
						dvrt_pkg::CMD_TICK: begin
							if (exp_q) begin
								upd_q <= 8'd1;
							end
						end
						dvrt_pkg::CMD_DUMP: begin
							dptr_q <= '0;
						end
						default: ;
					endcase
				end
				S_ADV2: begin
					rst_q   <= res_st;
					raddr_q <= res_addr;
					rcost_q <= res_cost;
					rifc_q  <= res_ifc;
					rbc_q   <= res_bc;
					if (!fa_q && !full) begin
						count_q <= count_q + 1'b1;
					end
					// report and clear the trigger at the end of a packet
					if (eop_q) begin
						pend_q <= 1'b0;
						if (pend_nx) begin
							upd_q <= 8'd1;
						end
					end else begin
						pend_q <= pend_nx;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						rsp.status        <= rst_q;
						rsp.out_address   <= raddr_q;
						rsp.out_cost      <= rcost_q;
						rsp.out_interface <= rifc_q;
						rsp.broadcast_due <= rbc_q;
						rsp.last_result   <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_DRD: begin
					if (out_free) begin
						state_q <= S_DWT;
					end
				end
				S_DWT: begin
					// the output slot is free here: load the dumped entry
					rsp.status        <= dvrt_pkg::ST_OK;
					rsp.out_address   <= rd_addr;
					rsp.out_cost      <= d_cost;
					rsp.out_interface <= d_ifc;
					rsp.broadcast_due <= 1'b0;
					rsp.last_result   <= (CW'(dptr_q + 1'b1) == count_q);
					dptr_q            <= dptr_q + 1'b1;
					state_q           <= (CW'(dptr_q + 1'b1) == count_q) ? S_IDLE : S_DRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = ovalid_q;
endmodule
